// ----- src/gcr_pkg.sv -----
// Shared types, constants and the inverse code map of the 9-to-8 group code decoder.
package gcr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CODE_W  = 9;
	localparam int unsigned GROUP_W = 9;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned CODE_COUNT = 256;

	localparam logic [CODE_W-1:0]  CODE_MASK    = 9'h1ff;
	localparam logic [BYTE_W-1:0]  BAD_BYTE     = 8'hff;
	localparam logic [GROUP_W-1:0] GROUPS_RESET = 9'd102;
	localparam logic [POS_W-1:0]   POS_FIRST    = 4'd0;
	localparam logic [POS_W-1:0]   POS_LAST     = 4'd8;

	// Forward code table: entry k is the codeword that carries user byte k.
	localparam logic [CODE_W-1:0] CODE_TABLE [CODE_COUNT] = '{
		9'h089, 9'h08a, 9'h08b, 9'h08c, 9'h08d, 9'h08e, 9'h091, 9'h092,
		9'h093, 9'h094, 9'h095, 9'h096, 9'h099, 9'h09a, 9'h09b, 9'h09c,
		9'h09d, 9'h09e, 9'h0a2, 9'h0a3, 9'h0a4, 9'h0a5, 9'h0a6, 9'h0a9,
		9'h0aa, 9'h0ab, 9'h0ac, 9'h0ad, 9'h0ae, 9'h0b1, 9'h0b2, 9'h0b3,
		9'h0b4, 9'h0b5, 9'h0b6, 9'h0b9, 9'h0ba, 9'h0bb, 9'h0bc, 9'h0bd,
		9'h0be, 9'h0c2, 9'h0c3, 9'h0c4, 9'h0c5, 9'h0c6, 9'h0c9, 9'h0ca,
		9'h0cb, 9'h0cc, 9'h0cd, 9'h0ce, 9'h0d1, 9'h0d2, 9'h0d3, 9'h0d4,
		9'h0d5, 9'h0d6, 9'h0d9, 9'h0da, 9'h0db, 9'h0dc, 9'h0dd, 9'h0de,
		9'h0e1, 9'h0e2, 9'h0e3, 9'h0e4, 9'h0e5, 9'h0e6, 9'h0e9, 9'h0ea,
		9'h0eb, 9'h0ec, 9'h0ed, 9'h0ee, 9'h0f1, 9'h0f2, 9'h0f3, 9'h0f4,
		9'h0f5, 9'h0f6, 9'h0f9, 9'h0fa, 9'h0fb, 9'h0fc, 9'h0fd, 9'h109,
		9'h10a, 9'h10b, 9'h10c, 9'h10d, 9'h10e, 9'h111, 9'h112, 9'h113,
		9'h114, 9'h115, 9'h116, 9'h119, 9'h11a, 9'h11b, 9'h11c, 9'h11d,
		9'h11e, 9'h121, 9'h122, 9'h123, 9'h124, 9'h125, 9'h126, 9'h129,
		9'h12a, 9'h12b, 9'h12c, 9'h12d, 9'h12e, 9'h131, 9'h132, 9'h133,
		9'h134, 9'h135, 9'h136, 9'h139, 9'h13a, 9'h13b, 9'h13c, 9'h13d,
		9'h13e, 9'h142, 9'h143, 9'h144, 9'h145, 9'h146, 9'h149, 9'h14a,
		9'h14b, 9'h14c, 9'h14d, 9'h14e, 9'h151, 9'h152, 9'h153, 9'h154,
		9'h155, 9'h156, 9'h159, 9'h15a, 9'h15b, 9'h15c, 9'h15d, 9'h15e,
		9'h161, 9'h162, 9'h163, 9'h164, 9'h165, 9'h166, 9'h169, 9'h16a,
		9'h16b, 9'h16c, 9'h16d, 9'h16e, 9'h171, 9'h172, 9'h173, 9'h174,
		9'h175, 9'h176, 9'h179, 9'h17a, 9'h17b, 9'h17c, 9'h17d, 9'h17e,
		9'h184, 9'h185, 9'h186, 9'h189, 9'h18a, 9'h18b, 9'h18c, 9'h18d,
		9'h18e, 9'h191, 9'h192, 9'h193, 9'h194, 9'h195, 9'h196, 9'h199,
		9'h19a, 9'h19b, 9'h19c, 9'h19d, 9'h19e, 9'h1a1, 9'h1a2, 9'h1a3,
		9'h1a4, 9'h1a5, 9'h1a6, 9'h1a9, 9'h1aa, 9'h1ab, 9'h1ac, 9'h1ad,
		9'h1ae, 9'h1b1, 9'h1b2, 9'h1b3, 9'h1b4, 9'h1b5, 9'h1b6, 9'h1b9,
		9'h1ba, 9'h1bb, 9'h1bc, 9'h1bd, 9'h1be, 9'h1c2, 9'h1c3, 9'h1c4,
		9'h1c5, 9'h1c6, 9'h1c9, 9'h1ca, 9'h1cb, 9'h1cc, 9'h1cd, 9'h1ce,
		9'h1d1, 9'h1d2, 9'h1d3, 9'h1d4, 9'h1d5, 9'h1d6, 9'h1d9, 9'h1da,
		9'h1db, 9'h1dc, 9'h1dd, 9'h1de, 9'h1e1, 9'h1e2, 9'h1e3, 9'h1e4,
		9'h1e5, 9'h1e6, 9'h1e9, 9'h1ea, 9'h1eb, 9'h1ec, 9'h1ed, 9'h1ee
	};

	// Result of decoding one codeword.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              raw_lsb;
	} gcr_word_t;

	// Inverse code map. Codewords are unique, so at most one entry matches;
	// every comparison is against a constant and the whole thing folds into a ROM.
	function automatic logic [BYTE_W-1:0] gcr_inverse(input logic [CODE_W-1:0] word);
		logic [BYTE_W-1:0] r;
		r = BAD_BYTE;
		for (int k = 0; k < CODE_COUNT; k++) begin
			if (CODE_TABLE[k] == word) begin
				r = BYTE_W'(k);
			end
		end
		return r;
	endfunction

endpackage

// ----- src/gcr_if.sv -----
// Valid/ready channel interfaces for received tape bytes and decoded data bytes.
interface gcr_tape_if
	import gcr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tape_byte;

	modport source (output valid, output tape_byte, input ready);
	modport sink   (input valid, input tape_byte, output ready);
endinterface

interface gcr_data_if
	import gcr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// ----- src/gcr_word_dec.sv -----
// Codeword extraction, transition inversion and inverse code mapping for one byte.
module gcr_word_dec
	import gcr_pkg::*;
(
	input  logic [BYTE_W-1:0] held_byte,
	input  logic [BYTE_W-1:0] tape_byte,
	input  logic [POS_W-1:0]  pos,
	input  logic              invert,
	output gcr_word_t         res
);

	logic [2*BYTE_W-1:0] window;
	logic [2:0]          shamt;
	logic [CODE_W-1:0]   raw_word;
	logic [CODE_W-1:0]   word;

	// Codeword j sits at bit offset 8 - j of the two-byte window.
	assign window   = {held_byte, tape_byte};
	assign shamt    = 3'(POS_LAST - pos);
	assign raw_word = CODE_W'(window >> shamt);
	assign word     = invert ? (raw_word ^ CODE_MASK) : raw_word;

	assign res.raw_lsb   = raw_word[0];
	assign res.data_byte = gcr_inverse(word);

endmodule

// ----- src/gcr_9b8b_nrzi_decoder_top.sv -----
// Top level of the 9-to-8 group code decoder with transition-inverted codewords.
// Each decoded byte is registered and shows in the cycle after its last tape byte is taken.
// One tape byte per cycle unless the receiver stalls a full output register; eight data
// bytes leave per nine tape bytes. Rate rests on the one-register inversion feedback.
// Reset (arst_n low, asynchronous): group position, group count, inversion flag and
// held byte clear, groups_per_block returns to 102 and the output register empties.
module gcr_9b8b_nrzi_decoder_top
	import gcr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	gcr_tape_if.sink            tape,
	gcr_data_if.source          data,
	input  logic                cfg_we,
	input  logic [GROUP_W-1:0]  cfg_wdata
);

	// Configuration register. Writes land at once and leave the stream position alone.
	logic [GROUP_W-1:0] groups_q;

	// Decoder state. held_q is the previous tape byte, pos_q the position of the next
	// byte in its nine-byte group, grp_q the groups already finished in this block and
	// inv_q the raw last bit of the previous codeword.
	logic [BYTE_W-1:0]  held_q;
	logic [POS_W-1:0]   pos_q;
	logic [GROUP_W-1:0] grp_q;
	logic               inv_q;

	// Output register; it is the only buffer between the two sides.
	logic               out_vld_s1;
	logic [BYTE_W-1:0]  out_byte_s1;
	logic               out_end_s1;

	logic               in_acc;
	logic               first_byte;
	logic               last_in_group;
	logic               last_group;
	logic [GROUP_W-1:0] last_grp_idx;
	gcr_word_t          dec;

	// A new transaction is taken whenever the output register is empty or is being
	// emptied in this very cycle, so back-to-back bytes flow with no bubble.
	assign tape.ready = !out_vld_s1 || data.ready;
	assign in_acc     = tape.valid && tape.ready;

	// The first byte of a group only primes the window and yields no data byte.
	assign first_byte    = (pos_q == POS_FIRST) || (pos_q > POS_LAST);
	assign last_in_group = (pos_q == POS_LAST);

	// A programmed count of zero wraps to the all-ones index and so behaves as 512 groups.
	assign last_grp_idx = groups_q - GROUP_W'(1);
	assign last_group   = (grp_q == last_grp_idx);

	gcr_word_dec u_word_dec (
		.held_byte (held_q),
		.tape_byte (tape.tape_byte),
		.pos       (pos_q),
		.invert    (inv_q),
		.res       (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= GROUPS_RESET;
		end else if (cfg_we) begin
			groups_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q  <= POS_FIRST;
			grp_q  <= '0;
			inv_q  <= 1'b0;
		end else if (in_acc) begin
			held_q <= tape.tape_byte;
			if (first_byte) begin
				pos_q <= POS_FIRST + POS_W'(1);
			end else if (last_in_group) begin
				// End of group: either close the block or move on to the next group.
				pos_q <= POS_FIRST;
				if (last_group) begin
					grp_q <= '0;
					inv_q <= 1'b0;
				end else begin
					grp_q <= grp_q + GROUP_W'(1);
					inv_q <= dec.raw_lsb;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				inv_q <= dec.raw_lsb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
		end else if (in_acc) begin
			out_vld_s1 <= !first_byte;
		end else if (data.ready) begin
			out_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !first_byte) begin
			out_byte_s1 <= dec.data_byte;
			out_end_s1  <= last_in_group && last_group;
		end
	end

	assign data.valid     = out_vld_s1;
	assign data.data_byte = out_byte_s1;
	assign data.block_end = out_end_s1;

	// The group position never leaves its nine-byte range.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("group position out of range");

	// A pending end-of-block byte means the state has already restarted for the next block.
	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		data.valid && data.block_end |-> grp_q == '0 && !inv_q && pos_q == POS_FIRST)
		else $error("block end pending without decoder restart");

	// The first byte of a group is only held: it moves the position on and adds no result.
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pos_q == POS_FIRST |=> pos_q == POS_FIRST + POS_W'(1) && !data.valid)
		else $error("first byte of a group mishandled");

	// An empty output register never holds back the input side.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!data.valid |-> tape.ready)
		else $error("input stalled with empty output register");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the 9-to-8 group code decoder, directed and random tape streams.
module testbench;
	import gcr_pkg::*;

	// One row of tape stimulus. Where typed is set, the decoded byte that the row
	// releases is written into the row itself; otherwise the predictor supplies it.
	typedef struct packed {
		logic [BYTE_W-1:0] tape_byte;
		logic              typed;
		logic [BYTE_W-1:0] data_byte;
		logic              block_end;
	} tape_row_t;

	// One decoded result as it leaves the block.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              block_end;
	} decoded_t;

	// The longest legal run without any transaction is a long sender gap followed by a
	// long receiver stall and the idle pause around a register write, all far below the limit.
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int GROUP_BITS    = 9 * BYTE_W;

	// Directed part. The first group is all zeros and the second all ones: every
	// codeword is invalid (a run of ones inverts to a run of zeros), so each decodes
	// to the error byte and no block ends under the reset setting of 102 groups.
	// The first byte of each group only fills the holding register and releases
	// nothing. The third group carries the codewords of the lowest and highest user
	// byte in turn, entered with the inversion flag set by the group before; the
	// predictor works out what it decodes to.
	localparam tape_row_t DIRECTED_ROWS [27] = '{
		'{8'h00, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b1, BAD_BYTE, 1'b0}, '{8'h00, 1'b1, BAD_BYTE, 1'b0},
		'{8'h00, 1'b1, BAD_BYTE, 1'b0}, '{8'h00, 1'b1, BAD_BYTE, 1'b0},
		'{8'h00, 1'b1, BAD_BYTE, 1'b0}, '{8'h00, 1'b1, BAD_BYTE, 1'b0},
		'{8'h00, 1'b1, BAD_BYTE, 1'b0}, '{8'h00, 1'b1, BAD_BYTE, 1'b0},
		'{8'hff, 1'b0, 8'h00, 1'b0},
		'{8'hff, 1'b1, BAD_BYTE, 1'b0}, '{8'hff, 1'b1, BAD_BYTE, 1'b0},
		'{8'hff, 1'b1, BAD_BYTE, 1'b0}, '{8'hff, 1'b1, BAD_BYTE, 1'b0},
		'{8'hff, 1'b1, BAD_BYTE, 1'b0}, '{8'hff, 1'b1, BAD_BYTE, 1'b0},
		'{8'hff, 1'b1, BAD_BYTE, 1'b0}, '{8'hff, 1'b1, BAD_BYTE, 1'b0},
		'{8'hbb, 1'b0, 8'h00, 1'b0}, '{8'h7b, 1'b0, 8'h00, 1'b0},
		'{8'h91, 1'b0, 8'h00, 1'b0}, '{8'h21, 1'b0, 8'h00, 1'b0},
		'{8'h1b, 1'b0, 8'h00, 1'b0}, '{8'hb7, 1'b0, 8'h00, 1'b0},
		'{8'hb9, 1'b0, 8'h00, 1'b0}, '{8'h12, 1'b0, 8'h00, 1'b0},
		'{8'h11, 1'b0, 8'h00, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [GROUP_W-1:0] cfg_wdata;

	gcr_tape_if tape_ch ();
	gcr_data_if data_ch ();

	gcr_9b8b_nrzi_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tape      (tape_ch),
		.data      (data_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Decoder mirror: holding register, position in the group, groups done in the
	// block, inversion flag and the groups-per-block setting, all at reset values.
	logic [BYTE_W-1:0]  held_q     = '0;
	logic [POS_W-1:0]   pos_q      = POS_FIRST;
	logic [GROUP_W-1:0] grp_q      = '0;
	logic               inv_q      = 1'b0;
	logic [GROUP_W-1:0] groups_cfg = GROUPS_RESET;

	// User byte for every 9-bit codeword, the error byte where none exists.
	logic [BYTE_W-1:0] byte_of_code [1 << CODE_W];

	// Encoder state used to build well-formed groups. It follows the same block
	// bookkeeping as the decoder so that its inversion flag stays in step.
	logic [GROUP_W-1:0] enc_grp    = '0;
	logic               enc_inv    = 1'b0;
	logic [GROUP_W-1:0] enc_groups = GROUPS_RESET;

	tape_row_t stream_q [$];
	decoded_t  expected_bytes [$];
	tape_row_t cur_row;
	bit        src_quiet;
	bit        sink_quiet;
	int        fail_count;
	int        idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Predicts the effect of one accepted tape byte. Returns 1 with the decoded
	// result where the byte completes a codeword, 0 for the first byte of a group.
	function automatic bit decode_tape_byte(input logic [BYTE_W-1:0] b, output decoded_t res);
		logic [2*BYTE_W-1:0] window;
		logic [CODE_W-1:0]   word;
		logic                raw_lsb;
		res = '0;
		if (pos_q == POS_FIRST || pos_q > POS_LAST) begin
			held_q = b;
			pos_q  = POS_FIRST + POS_W'(1);
			return 1'b0;
		end
		window  = {held_q, b};
		word    = CODE_W'(window >> (8 - pos_q));
		raw_lsb = word[0];
		if (inv_q) begin
			word = word ^ CODE_MASK;
		end
		inv_q  = raw_lsb;
		held_q = b;
		res.data_byte = byte_of_code[word];
		if (pos_q == POS_LAST) begin
			pos_q = POS_FIRST;
			// The last group is found modulo 512, so a setting of zero means 512 groups
			// and a setting lowered below the current count only ends after the wrap.
			if (grp_q == GROUP_W'(groups_cfg - GROUP_W'(1))) begin
				res.block_end = 1'b1;
				grp_q = '0;
				inv_q = 1'b0;
			end else begin
				grp_q = grp_q + GROUP_W'(1);
			end
		end else begin
			pos_q = pos_q + POS_W'(1);
		end
		return 1'b1;
	endfunction

	// Gap before a transaction or length of a receiver stall: mostly none or short,
	// now and then long.
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Block bookkeeping of the encoder at the end of a group; last_bit is the raw
	// final bit of the group, which sets the inversion of the next codeword.
	function automatic void close_group(input logic last_bit);
		if (enc_grp == GROUP_W'(enc_groups - GROUP_W'(1))) begin
			enc_grp = '0;
			enc_inv = 1'b0;
		end else begin
			enc_grp = enc_grp + GROUP_W'(1);
			enc_inv = last_bit;
		end
	endfunction

	// Queues one group of nine tape bytes. Most groups are proper encodings of random
	// user bytes; some carry a single flipped bit and some are pure noise.
	task automatic queue_group();
		logic [GROUP_BITS-1:0] bits;
		logic [CODE_W-1:0]     cw;
		logic                  inv;
		tape_row_t             row;
		int                    kind;
		int                    flip;
		kind = $urandom_range(0, 99);
		flip = $urandom_range(0, GROUP_BITS - 1);
		inv  = enc_inv;
		for (int j = 0; j < 8; j++) begin
			cw = CODE_TABLE[$urandom_range(0, CODE_COUNT - 1)];
			if (inv) begin
				cw = cw ^ CODE_MASK;
			end
			inv = cw[0];
			bits[GROUP_BITS - 1 - CODE_W * j -: CODE_W] = cw;
		end
		if (kind >= 85) begin
			bits = GROUP_BITS'({$urandom(), $urandom(), $urandom()});
		end else if (kind >= 70) begin
			bits[flip] = ~bits[flip];
		end
		row = '0;
		for (int i = 0; i < 9; i++) begin
			row.tape_byte = bits[GROUP_BITS - 1 - BYTE_W * i -: BYTE_W];
			stream_q.push_back(row);
		end
		close_group(bits[0]);
	endtask

	// Offers every queued tape byte in turn, each after a random gap, and returns once
	// the prediction for the last transaction is already queued.
	task automatic send_stream();
		tape_row_t row;
		int        gap;
		while (stream_q.size() != 0) begin
			row = stream_q.pop_front();
			gap = pick_gap(src_quiet);
			if (gap > 0) begin
				tape_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tape_ch.valid     <= 1'b1;
			tape_ch.tape_byte <= row.tape_byte;
			cur_row           <= row;
			do @(posedge clk); while (!tape_ch.ready);
		end
		tape_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected byte has come out, then waits on for a drain period in case a
	// first byte of a group, which releases nothing, is still inside the block.
	task automatic wait_drained();
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_groups_per_block(input logic [GROUP_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		enc_groups = value;
	endtask

	// One phase: an optional register write while the block is idle, then a number of
	// whole groups. A quiet phase runs both sides without any idling.
	task automatic run_phase(input bit do_write, input logic [GROUP_W-1:0] value,
			input int groups, input bit quiet);
		wait_drained();
		if (do_write) begin
			write_groups_per_block(value);
		end
		src_quiet  = quiet;
		sink_quiet = quiet;
		repeat (groups) queue_group();
		send_stream();
	endtask

	// Receiver: holds ready low for random stalls between stretches of acceptance.
	initial begin
		int stall;
		data_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = pick_gap(sink_quiet);
			if (stall > 0) begin
				data_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			data_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Monitor: at each rising edge it sees the values from before the edge, updates
	// the mirror with any register write or tape transaction, checks any output
	// transaction against the oldest expectation, and keeps the watchdog.
	always @(posedge clk) begin
		decoded_t want;
		bit       tape_fire;
		bit       data_fire;
		if (arst_n) begin
			tape_fire = tape_ch.valid && tape_ch.ready;
			data_fire = data_ch.valid && data_ch.ready;
			if (cfg_we) begin
				groups_cfg = cfg_wdata;
			end
			if (tape_fire && decode_tape_byte(tape_ch.tape_byte, want)) begin
				if (cur_row.typed) begin
					want = {cur_row.data_byte, cur_row.block_end};
				end
				expected_bytes.push_back(want);
			end
			if (data_fire) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					$error("unexpected data byte %0h, block_end %0b",
						data_ch.data_byte, data_ch.block_end);
				end else begin
					want = expected_bytes.pop_front();
					if (data_ch.data_byte !== want.data_byte) begin
						fail_count++;
						$error("data_byte: expected %0h, got %0h",
							want.data_byte, data_ch.data_byte);
					end
					if (data_ch.block_end !== want.block_end) begin
						fail_count++;
						$error("block_end: expected %0b, got %0b",
							want.block_end, data_ch.block_end);
					end
				end
			end
			if (tape_fire || data_fire || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int c = 0; c < (1 << CODE_W); c++) begin
			byte_of_code[c] = BAD_BYTE;
		end
		for (int k = 0; k < CODE_COUNT; k++) begin
			byte_of_code[CODE_TABLE[k]] = BYTE_W'(k);
		end
		fail_count  = 0;
		idle_cycles = 0;
		src_quiet   = 1'b0;
		sink_quiet  = 1'b0;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		tape_ch.valid     <= 1'b0;
		tape_ch.tape_byte <= '0;
		cur_row           <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset setting, then the encoder is brought level
		// with the three groups they form.
		foreach (DIRECTED_ROWS[i]) begin
			stream_q.push_back(DIRECTED_ROWS[i]);
		end
		send_stream();
		for (int g = 0; g < 3; g++) begin
			close_group(DIRECTED_ROWS[9 * g + 8].tape_byte[0]);
		end

		// Still at the reset setting: the block of 102 groups ends on the last group
		// of this phase.
		run_phase(1'b0, '0, 99, 1'b0);
		// Zero acts as 512 groups, so no block ends in 20 groups. Raising the setting
		// to 25 then closes the block after five more.
		run_phase(1'b1, 9'd0, 20, 1'b0);
		run_phase(1'b1, 9'd25, 5, 1'b0);
		// Short blocks, each phase ending on a block boundary.
		run_phase(1'b1, 9'd1, 10, 1'b1);
		run_phase(1'b1, 9'd2, 8, 1'b0);
		run_phase(1'b1, 9'd3, 6, 1'b0);
		// Random short settings, always above the count already reached.
		repeat (4) begin
			run_phase(1'b1, enc_grp + GROUP_W'($urandom_range(1, 6)), 6,
				$urandom_range(0, 3) == 0);
		end
		// Largest setting last, since a lower setting afterwards would need a wrap.
		run_phase(1'b1, 9'd511, 15, 1'b0);

		wait_drained();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
